// ===== sv/gerl_pkg.sv =====
// Shared types, constants and helper functions for the gear event record logger.
// No dependencies; every other file of the block imports this package.
package gerl_pkg;

    localparam int RING_SLOTS_DEF  = 10;
    localparam int RECORD_LEN      = 10;
    localparam int ADDR_W          = 7;
    localparam int SCALE_W         = 16;
    localparam int SAMPLE_W        = 10;
    localparam int PROD_W          = SCALE_W + SAMPLE_W;
    localparam int SPEED_W         = 7;
    localparam int IDX_W           = $clog2(RECORD_LEN);

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd6344;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd99;
    localparam logic [7:0]         ASCII_ZERO  = 8'd48;

    typedef enum logic [1:0] {
        KEY_NONE = 2'd0,
        KEY_COLL = 2'd1,
        KEY_UP   = 2'd2,
        KEY_DOWN = 2'd3
    } t_key;

    typedef enum logic [2:0] {
        GEAR_ON   = 3'd0,
        GEAR_GR   = 3'd1,
        GEAR_GN   = 3'd2,
        GEAR_G1   = 3'd3,
        GEAR_G2   = 3'd4,
        GEAR_G3   = 3'd5,
        GEAR_G4   = 3'd6,
        GEAR_COLL = 3'd7
    } t_gear;

    typedef logic [7:0] t_byte;
    typedef t_byte [RECORD_LEN-1:0] t_record;

    // One registered poll: key, clock bytes and the raw scaled speed product.
    typedef struct packed {
        t_key              key;
        logic [7:0]        hour;
        logic [7:0]        minute;
        logic [7:0]        second;
        logic [PROD_W-1:0] product;
    } t_poll;

    // Record handed from the event logic to the byte emitter.
    typedef struct packed {
        logic              emit;
        logic [ADDR_W-1:0] base;
        logic              wrap;
        t_record           bytes;
    } t_rec_req;

    function automatic t_byte ascii_digit(input logic [3:0] nib);
        return ASCII_ZERO + {4'b0000, nib};
    endfunction

    function automatic t_byte event_char_hi(input t_gear g);
        t_byte c;
        case (g)
            GEAR_ON:   c = "O";
            GEAR_COLL: c = "C";
            default:   c = "G";
        endcase
        return c;
    endfunction

    function automatic t_byte event_char_lo(input t_gear g);
        t_byte c;
        case (g)
            GEAR_ON:   c = "N";
            GEAR_GR:   c = "R";
            GEAR_GN:   c = "N";
            GEAR_G1:   c = "1";
            GEAR_G2:   c = "2";
            GEAR_G3:   c = "3";
            GEAR_G4:   c = "4";
            default:   c = " ";
        endcase
        return c;
    endfunction

endpackage

// ===== sv/gerl_front.sv =====
// Input register of the logger: poll capture, speed scale register and speed product.
// Depends on gerl_pkg.
module gerl_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_key_event,
    input  logic [7:0]                     i_hour_bcd,
    input  logic [7:0]                     i_minute_bcd,
    input  logic [7:0]                     i_second_bcd,
    input  logic [gerl_pkg::SAMPLE_W-1:0]  i_speed_sample,
    input  logic                           i_cfg_valid,
    input  logic [gerl_pkg::SCALE_W-1:0]   i_cfg_data,
    input  logic                           i_take,
    output logic                           o_poll_valid,
    output gerl_pkg::t_poll                o_poll
);
    import gerl_pkg::*;

    logic                r_valid;
    t_poll               r_poll;
    logic [SCALE_W-1:0]  r_scale;
    logic                accept;

    assign o_in_ready = !r_valid || i_take;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_poll.key     <= t_key'(i_key_event);
            r_poll.hour    <= i_hour_bcd;
            r_poll.minute  <= i_minute_bcd;
            r_poll.second  <= i_second_bcd;
            r_poll.product <= PROD_W'(i_speed_sample) * PROD_W'(r_scale);
        end
    end

    assign o_poll_valid = r_valid;
    assign o_poll       = r_poll;

endmodule

// ===== sv/gerl_event.sv =====
// Gear/event state, ring slot tracking and ASCII record assembly.
// Depends on gerl_pkg.
module gerl_event #(
    parameter int RING_SLOTS = gerl_pkg::RING_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_poll_valid,
    input  gerl_pkg::t_poll     i_poll,
    input  logic                i_take,
    output gerl_pkg::t_rec_req  o_rec
);
    import gerl_pkg::*;

    localparam int SLOT_W  = $clog2(RING_SLOTS);
    localparam int FULL_W  = $clog2(RING_SLOTS * RECORD_LEN + 1);
    localparam int SUM_W   = (FULL_W > ADDR_W) ? FULL_W : ADDR_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

    t_gear              r_gear;
    t_gear              n_gear;
    logic               r_hold;
    logic               n_hold;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_wrap;
    logic [2:0]         gear_up;
    logic [2:0]         gear_dn;
    logic [SAMPLE_W-1:0] spd_raw;
    logic [SPEED_W-1:0] spd;
    logic [14:0]        tens_mul;
    logic [3:0]         tens;
    logic [SPEED_W-1:0] ones_full;
    logic [1:0]         hour_tens;
    logic [SUM_W-1:0]   base_full;

    assign gear_up = r_gear + 3'd1;
    assign gear_dn = r_gear - 3'd1;

    always_comb begin
        n_gear = r_gear;
        n_hold = r_hold;
        case (i_poll.key)
            KEY_COLL: begin
                n_gear = GEAR_COLL;
                n_hold = 1'b0;
            end
            KEY_UP: begin
                if (r_gear == GEAR_COLL) begin
                    n_gear = GEAR_GN;
                    n_hold = 1'b0;
                end else if (r_gear != GEAR_G4) begin
                    n_gear = t_gear'(gear_up);
                    n_hold = 1'b0;
                end
            end
            KEY_DOWN: begin
                if (r_gear == GEAR_COLL) begin
                    n_gear = GEAR_GN;
                    n_hold = 1'b0;
                end else if (r_gear != GEAR_ON && r_gear != GEAR_GR) begin
                    n_gear = t_gear'(gear_dn);
                    n_hold = 1'b0;
                end
            end
            default: begin
                n_hold = 1'b1;
            end
        endcase
    end

    // Saturate speed, then split into digits with a reciprocal multiply.
    assign spd_raw   = i_poll.product[PROD_W-1:SCALE_W];
    assign spd       = (spd_raw > SAMPLE_W'(SPEED_MAX)) ? SPEED_MAX : spd_raw[SPEED_W-1:0];
    assign tens_mul  = 15'(spd) * 15'd205;
    assign tens      = tens_mul[14:11];
    assign ones_full = spd - SPEED_W'(tens) * SPEED_W'(10);

    assign hour_tens = i_poll.hour[6] ? {1'b0, i_poll.hour[4]} : i_poll.hour[5:4];
    assign base_full = SUM_W'(r_slot) * SUM_W'(RECORD_LEN);

    always_comb begin
        o_rec.emit     = i_poll_valid && !n_hold;
        o_rec.base     = base_full[ADDR_W-1:0];
        o_rec.wrap     = r_wrap;
        o_rec.bytes[0] = ascii_digit({2'b00, hour_tens});
        o_rec.bytes[1] = ascii_digit(i_poll.hour[3:0]);
        o_rec.bytes[2] = ascii_digit(i_poll.minute[7:4]);
        o_rec.bytes[3] = ascii_digit(i_poll.minute[3:0]);
        o_rec.bytes[4] = ascii_digit(i_poll.second[7:4]);
        o_rec.bytes[5] = ascii_digit(i_poll.second[3:0]);
        o_rec.bytes[6] = event_char_hi(n_gear);
        o_rec.bytes[7] = event_char_lo(n_gear);
        o_rec.bytes[8] = ascii_digit(tens);
        o_rec.bytes[9] = ascii_digit(ones_full[3:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear <= GEAR_ON;
            r_hold <= 1'b0;
            r_slot <= '0;
            r_wrap <= 1'b0;
        end else if (i_take) begin
            r_gear <= n_gear;
            r_hold <= n_hold;
            if (!n_hold) begin
                if (r_slot >= LAST_SLOT) begin
                    r_slot <= '0;
                    r_wrap <= 1'b1;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end
        end
    end

endmodule

// ===== sv/gerl_emit.sv =====
// Result register of the logger: holds one record and sends it one byte per beat.
// Depends on gerl_pkg.
module gerl_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  gerl_pkg::t_rec_req           i_rec,
    output logic                         o_can_load,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [gerl_pkg::ADDR_W-1:0]  o_mem_address,
    output logic [7:0]                   o_mem_byte,
    output logic                         o_last_of_record,
    output logic                         o_ring_wrapped
);
    import gerl_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_LEN - 1);

    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    t_record            r_bytes;
    logic [ADDR_W-1:0]  r_base;
    logic               r_wrap;
    logic               beat;
    logic               last;

    assign beat       = r_busy && i_out_ready;
    assign last       = (r_idx == LAST_IDX);
    assign o_can_load = !r_busy || (beat && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (beat) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Shift the record down one byte per beat.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_rec.bytes;
            r_base  <= i_rec.base;
            r_wrap  <= i_rec.wrap;
        end else if (beat) begin
            r_bytes <= {8'h00, r_bytes[RECORD_LEN-1:1]};
        end
    end

    assign o_out_valid      = r_busy;
    assign o_mem_address    = r_base + ADDR_W'(r_idx);
    assign o_mem_byte       = r_bytes[0];
    assign o_last_of_record = last;
    assign o_ring_wrapped   = r_wrap;

endmodule

// ===== sv/gear_event_record_logger.sv =====
// Gear event record logger. Each input beat is one poll (key event, BCD clock
// bytes, raw speed sample). The block tracks the gear/event state and, whenever
// the poll changes it (or on any collision, or on a blocked gear key while the
// hold flag is clear), sends a ten-byte ASCII record to consecutive log
// addresses: hour, minute and second digits, two event characters and two speed
// digits. While no logging poll waits for the emitter, the input side accepts
// one every cycle. A poll that logs a record takes ten output beats; the byte
// emitter has a single record buffer, so the next logging poll waits in the
// input register until the last byte of the previous record leaves. Write
// speed_scale only while no record is pending. Depends on gerl_pkg, gerl_front,
// gerl_event and gerl_emit.
module gear_event_record_logger #(
    parameter int RING_SLOTS = gerl_pkg::RING_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // poll channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_key_event,
    input  logic [7:0]                     i_hour_bcd,
    input  logic [7:0]                     i_minute_bcd,
    input  logic [7:0]                     i_second_bcd,
    input  logic [gerl_pkg::SAMPLE_W-1:0]  i_speed_sample,
    // configuration write channel (speed_scale)
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gerl_pkg::SCALE_W-1:0]   i_cfg_data,
    // record byte channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [gerl_pkg::ADDR_W-1:0]    o_mem_address,
    output logic [7:0]                     o_mem_byte,
    output logic                           o_last_of_record,
    output logic                           o_ring_wrapped
);
    import gerl_pkg::*;

    logic      poll_valid;
    t_poll     poll;
    t_rec_req  rec;
    logic      can_load;
    logic      take;

    // Retire the held poll when it logs nothing or the emitter is free.
    assign take        = poll_valid && (!rec.emit || can_load);
    assign o_cfg_ready = 1'b1;

    gerl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_key_event    (i_key_event),
        .i_hour_bcd     (i_hour_bcd),
        .i_minute_bcd   (i_minute_bcd),
        .i_second_bcd   (i_second_bcd),
        .i_speed_sample (i_speed_sample),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_take         (take),
        .o_poll_valid   (poll_valid),
        .o_poll         (poll)
    );

    gerl_event #(
        .RING_SLOTS (RING_SLOTS)
    ) u_event (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poll_valid (poll_valid),
        .i_poll       (poll),
        .i_take       (take),
        .o_rec        (rec)
    );

    gerl_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (take && rec.emit),
        .i_rec            (rec),
        .o_can_load       (can_load),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mem_address    (o_mem_address),
        .o_mem_byte       (o_mem_byte),
        .o_last_of_record (o_last_of_record),
        .o_ring_wrapped   (o_ring_wrapped)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for gear_event_record_logger: polls in, ASCII log bytes out.
// Uses gerl_pkg for widths, key and gear codes; compares every byte with its own model.
`timescale 1ns / 1ps

module testbench;
    import gerl_pkg::*;

    localparam int RING_SLOTS   = RING_SLOTS_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TICKS = 20;   // covers a non-logging poll still in the input register
    localparam int SINK_HOLD    = 200;  // long receiver hold-off, in cycles

    // One expected log byte.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              last;
        logic              wrap;
    } t_log_beat;

    // One row of the directed stimulus; a nonzero text is the record typed in by hand.
    typedef struct packed {
        t_key              key;
        logic [7:0]        hour;
        logic [7:0]        minute;
        logic [7:0]        second;
        logic [SAMPLE_W-1:0] sample;
        logic [8*RECORD_LEN-1:0] text;
    } t_poll_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_key_event;
    logic [7:0]            i_hour_bcd;
    logic [7:0]            i_minute_bcd;
    logic [7:0]            i_second_bcd;
    logic [SAMPLE_W-1:0]   i_speed_sample;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [SCALE_W-1:0]    i_cfg_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [ADDR_W-1:0]     o_mem_address;
    logic [7:0]            o_mem_byte;
    logic                  o_last_of_record;
    logic                  o_ring_wrapped;

    gear_event_record_logger #(
        .RING_SLOTS(RING_SLOTS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_key_event     (i_key_event),
        .i_hour_bcd      (i_hour_bcd),
        .i_minute_bcd    (i_minute_bcd),
        .i_second_bcd    (i_second_bcd),
        .i_speed_sample  (i_speed_sample),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mem_address   (o_mem_address),
        .o_mem_byte      (o_mem_byte),
        .o_last_of_record(o_last_of_record),
        .o_ring_wrapped  (o_ring_wrapped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Logger model: gear/event index, hold flag, ring slot, wrap flag, scale.
    // ------------------------------------------------------------------
    t_gear             gear_now    = GEAR_ON;
    logic              hold_now    = 1'b0;
    int                slot_now    = 0;
    logic              wrapped_now = 1'b0;
    logic [SCALE_W-1:0] scale_now  = SCALE_RESET;

    t_log_beat         log_bytes_due[$];   // bytes still owed by the block, oldest first
    logic [8*RECORD_LEN-1:0] typed_record = '0;  // hand-typed record of the poll on the bus

    int unsigned fail_count    = 0;
    int unsigned polls_taken   = 0;
    int unsigned bytes_checked = 0;
    int unsigned records_seen  = 0;
    int unsigned scale_writes  = 0;
    int unsigned cycle_count   = 0;
    logic        idle_on       = 1'b1;   // random idling on both sides
    logic        sink_hold_req = 1'b0;   // ask the receiver for one long hold-off

    // Update the gear state for one poll and queue the record it logs, if any.
    task automatic predict_record(input t_key key, input logic [7:0] hour,
                                  input logic [7:0] minute, input logic [7:0] second,
                                  input logic [SAMPLE_W-1:0] sample,
                                  input logic [8*RECORD_LEN-1:0] text);
        logic [PROD_W-1:0] product;
        logic [9:0]        speed;
        logic [7:0]        rec [RECORD_LEN];
        t_log_beat         beat;

        case (key)
            KEY_COLL: begin
                // collision always logs, even when already in collision
                gear_now = GEAR_COLL;
                hold_now = 1'b0;
            end
            KEY_UP: begin
                if (gear_now == GEAR_COLL) begin
                    gear_now = GEAR_GN;
                    hold_now = 1'b0;
                end else if (gear_now != GEAR_G4) begin
                    gear_now = t_gear'(gear_now + 3'd1);
                    hold_now = 1'b0;
                end
            end
            KEY_DOWN: begin
                if (gear_now == GEAR_COLL) begin
                    gear_now = GEAR_GN;
                    hold_now = 1'b0;
                end else if (gear_now != GEAR_ON && gear_now != GEAR_GR) begin
                    gear_now = t_gear'(gear_now - 3'd1);
                    hold_now = 1'b0;
                end
            end
            default: hold_now = 1'b1;
        endcase

        // a blocked step keeps the hold flag, so it repeats a record if it was clear
        if (hold_now) begin
            if (text != '0) begin
                $error("directed row expects record %s, model logs none", text);
                fail_count++;
            end
            return;
        end

        product = sample * scale_now;
        speed   = product[PROD_W-1:16];
        if (speed > 10'd99)
            speed = 10'd99;

        // 12-hour mode keeps only bit 4 of the tens digit; non-BCD nibbles go past '9'
        rec[0] = 8'd48 + (hour[6] ? {7'd0, hour[4]} : {6'd0, hour[5:4]});
        rec[1] = 8'd48 + {4'd0, hour[3:0]};
        rec[2] = 8'd48 + {4'd0, minute[7:4]};
        rec[3] = 8'd48 + {4'd0, minute[3:0]};
        rec[4] = 8'd48 + {4'd0, second[7:4]};
        rec[5] = 8'd48 + {4'd0, second[3:0]};
        case (gear_now)
            GEAR_ON:   begin rec[6] = "O"; rec[7] = "N"; end
            GEAR_GR:   begin rec[6] = "G"; rec[7] = "R"; end
            GEAR_GN:   begin rec[6] = "G"; rec[7] = "N"; end
            GEAR_G1:   begin rec[6] = "G"; rec[7] = "1"; end
            GEAR_G2:   begin rec[6] = "G"; rec[7] = "2"; end
            GEAR_G3:   begin rec[6] = "G"; rec[7] = "3"; end
            GEAR_G4:   begin rec[6] = "G"; rec[7] = "4"; end
            default:   begin rec[6] = "C"; rec[7] = " "; end
        endcase
        rec[8] = 8'd48 + 8'(speed / 10);
        rec[9] = 8'd48 + 8'(speed % 10);

        for (int i = 0; i < RECORD_LEN; i++) begin
            beat.addr = ADDR_W'(slot_now * RECORD_LEN + i);
            beat.data = (text != '0) ? text[8*(RECORD_LEN-i)-1 -: 8] : rec[i];
            beat.last = (i == RECORD_LEN - 1);
            beat.wrap = wrapped_now;
            log_bytes_due.push_back(beat);
        end

        // advance the ring; the wrap flag shows on the next record
        if (slot_now >= RING_SLOTS - 1) begin
            slot_now    = 0;
            wrapped_now = 1'b1;
        end else begin
            slot_now++;
        end
    endtask

    // Compare one accepted log byte with the oldest expectation.
    task automatic check_log_byte();
        t_log_beat want;

        if (log_bytes_due.size() == 0) begin
            $error("unexpected log byte: address %0d, byte %h", o_mem_address, o_mem_byte);
            fail_count++;
            return;
        end
        want = log_bytes_due.pop_front();
        bytes_checked++;
        if (o_last_of_record)
            records_seen++;
        if (o_mem_address !== want.addr) begin
            $error("mem_address: expected %0d, actual %0d", want.addr, o_mem_address);
            fail_count++;
        end
        if (o_mem_byte !== want.data) begin
            $error("mem_byte: expected %h, actual %h", want.data, o_mem_byte);
            fail_count++;
        end
        if (o_last_of_record !== want.last) begin
            $error("last_of_record: expected %b, actual %b", want.last, o_last_of_record);
            fail_count++;
        end
        if (o_ring_wrapped !== want.wrap) begin
            $error("ring_wrapped: expected %b, actual %b", want.wrap, o_ring_wrapped);
            fail_count++;
        end
    endtask

    // Watch all three channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                scale_now = i_cfg_data;
                scale_writes++;
            end
            if (o_out_valid && i_out_ready)
                check_log_byte();
            if (i_in_valid && o_in_ready) begin
                predict_record(t_key'(i_key_event), i_hour_bcd, i_minute_bcd, i_second_bcd,
                               i_speed_sample, typed_record);
                polls_taken++;
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d log bytes still owed",
                     cycle_count, log_bytes_due.size());
            $display("[gear_event_record_logger] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: runs of ready, random stall bursts, one long hold on request.
    // Exactly one assignment to i_out_ready per falling edge.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        int run;

        i_out_ready = 1'b0;
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                repeat (SINK_HOLD) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 19);
                repeat (stall) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end else begin
                run = $urandom_range(1, 30);
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one poll and hold it until the block takes it.
    task automatic send_poll(input t_key key, input logic [7:0] hour,
                             input logic [7:0] minute, input logic [7:0] second,
                             input logic [SAMPLE_W-1:0] sample,
                             input logic [8*RECORD_LEN-1:0] text);
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_key_event    <= key;
        i_hour_bcd     <= hour;
        i_minute_bcd   <= minute;
        i_second_bcd   <= second;
        i_speed_sample <= sample;
        typed_record    = text;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Drop valid for a random burst now and then.
    task automatic sender_gap();
        int gap;

        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge i_clk);
        end
    endtask

    // Stop offering, wait for every owed byte, then let the pipeline go quiet.
    task automatic drain_log();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (log_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS)
            @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random clock byte: half legal BCD up to the given tens digit, half anything.
    function automatic logic [7:0] clock_byte(input int tens_max);
        if ($urandom_range(0, 1))
            return 8'($urandom_range(0, 255));
        return 8'(($urandom_range(0, tens_max) << 4) | $urandom_range(0, 9));
    endfunction

    task automatic send_random_polls(input int count, input int max_sample);
        int          pick;
        t_key        key;
        logic [7:0]  hour;
        logic [SAMPLE_W-1:0] sample;

        repeat (count) begin
            // mostly gear steps and collisions so records keep flowing
            pick = $urandom_range(0, 99);
            if (pick < 20)
                key = KEY_NONE;
            else if (pick < 35)
                key = KEY_COLL;
            else if (pick < 68)
                key = KEY_UP;
            else
                key = KEY_DOWN;
            hour = clock_byte(2) | 8'($urandom_range(0, 1) << 6);
            case ($urandom_range(0, 9))
                0:       sample = '0;
                1:       sample = SAMPLE_W'(max_sample);
                default: sample = SAMPLE_W'($urandom_range(0, max_sample));
            endcase
            sender_gap();
            send_poll(key, hour, clock_byte(5), clock_byte(5), sample, '0);
        end
    endtask

    initial begin
        t_poll_row directed_rows[$];

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_key_event    = KEY_NONE;
        i_hour_bcd     = '0;
        i_minute_bcd   = '0;
        i_second_bcd   = '0;
        i_speed_sample = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;

        // Directed table, walked at the reset scale. Typed records cover the
        // reset state, clock-byte extremes, 12-hour mode and speed saturation.
        directed_rows.push_back('{KEY_DOWN, 8'h12, 8'h34, 8'h56, 10'd0,    "123456ON00"});
        directed_rows.push_back('{KEY_NONE, 8'h99, 8'h99, 8'h99, 10'd300,  '0});
        directed_rows.push_back('{KEY_DOWN, 8'h01, 8'h02, 8'h03, 10'd4,    '0});
        directed_rows.push_back('{KEY_UP,   8'h45, 8'h00, 8'h09, 10'd1023, "050009GR99"});
        directed_rows.push_back('{KEY_UP,   8'h30, 8'h59, 8'h59, 10'd512,  '0});
        directed_rows.push_back('{KEY_UP,   8'h08, 8'h15, 8'h27, 10'd100,  '0});
        directed_rows.push_back('{KEY_UP,   8'h19, 8'h20, 8'h21, 10'd200,  '0});
        directed_rows.push_back('{KEY_UP,   8'h22, 8'h33, 8'h44, 10'd700,  '0});
        directed_rows.push_back('{KEY_UP,   8'h11, 8'h11, 8'h11, 10'd1022, '0});
        // blocked up key in G4 with the hold flag clear: record repeats
        directed_rows.push_back('{KEY_UP,   8'h00, 8'h00, 8'h00, 10'd0,    "000000G400"});
        directed_rows.push_back('{KEY_NONE, 8'h55, 8'h55, 8'h55, 10'd55,   '0});
        directed_rows.push_back('{KEY_UP,   8'h06, 8'h07, 8'h08, 10'd9,    '0});
        directed_rows.push_back('{KEY_DOWN, 8'h13, 8'h14, 8'h15, 10'd16,   '0});
        // this record fills the last ring slot and wraps the ring
        directed_rows.push_back('{KEY_COLL, 8'h72, 8'hFF, 8'hAA, 10'd1023, "12??::C 99"});
        // collision while in collision logs again, first record after the wrap
        directed_rows.push_back('{KEY_COLL, 8'hFF, 8'hF0, 8'h0F, 10'd0,    "1??00?C 00"});
        directed_rows.push_back('{KEY_UP,   8'h20, 8'h00, 8'h01, 10'd800,  '0});
        directed_rows.push_back('{KEY_COLL, 8'h21, 8'h10, 8'h02, 10'd850,  '0});
        directed_rows.push_back('{KEY_DOWN, 8'h22, 8'h20, 8'h03, 10'd900,  '0});
        directed_rows.push_back('{KEY_DOWN, 8'hBF, 8'h30, 8'h04, 10'd950,  '0});
        directed_rows.push_back('{KEY_DOWN, 8'h40, 8'h40, 8'h05, 10'd1000, '0});
        directed_rows.push_back('{KEY_NONE, 8'h41, 8'h50, 8'h06, 10'd64,   '0});
        directed_rows.push_back('{KEY_COLL, 8'h52, 8'h59, 8'h07, 10'd128,  '0});
        directed_rows.push_back('{KEY_NONE, 8'h63, 8'h00, 8'h08, 10'd256,  '0});
        directed_rows.push_back('{KEY_COLL, 8'h7F, 8'h5A, 8'hA5, 10'd511,  '0});

        // Hold synchronous reset, then release it on a falling edge.
        repeat (7)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            sender_gap();
            send_poll(directed_rows[r].key, directed_rows[r].hour, directed_rows[r].minute,
                      directed_rows[r].second, directed_rows[r].sample, directed_rows[r].text);
        end
        drain_log();

        // Full scale: small samples give speeds from 0 up to saturation.
        write_scale(16'hFFFF);
        send_random_polls(70, 127);
        drain_log();

        // Zero scale, then hold the receiver off while collisions pile up
        // back to back, so the block fills and stalls its input.
        write_scale(16'h0000);
        sink_hold_req = 1'b1;
        repeat (20)
            send_poll(KEY_COLL, clock_byte(2), clock_byte(5), clock_byte(5),
                      SAMPLE_W'($urandom_range(0, 1023)), '0);
        send_random_polls(50, 1023);
        drain_log();

        write_scale(16'h0001);
        send_random_polls(70, 1023);
        drain_log();

        write_scale(16'($urandom_range(0, 65535)));
        send_random_polls(70, 1023);
        drain_log();

        write_scale(SCALE_RESET);
        send_random_polls(70, 1023);
        drain_log();

        // Last stretch: random scale, no idling on either side.
        write_scale(16'($urandom_range(1000, 20000)));
        idle_on = 1'b0;
        send_random_polls(70, 1023);
        drain_log();

        $display("covered %0d polls through every gear step, collision and blocked key,",
                 polls_taken);
        $display("%0d log bytes in %0d records checked over %0d scale settings",
                 bytes_checked, records_seen, scale_writes);
        if (fail_count == 0)
            $display("[gear_event_record_logger] OK");
        else
            $display("[gear_event_record_logger] ERROR");
        $finish;
    end

endmodule
